// ===== rtl/valid_2d_convolution_defines.svh =====
// Assertion helpers for valid_2d_convolution
`ifndef VALID_2D_CONVOLUTION_DEFINES_SVH
`define VALID_2D_CONVOLUTION_DEFINES_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define V2DC_ASSERT_IMP(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("assertion failed: implication");
// next-cycle implication
`define V2DC_ASSERT_NXT(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("assertion failed: next cycle");
`else
`define V2DC_ASSERT_IMP(label, clk, rst_n, pre, post)
`define V2DC_ASSERT_NXT(label, clk, rst_n, pre, post)
`endif

`endif

// ===== rtl/v2dc_pkg.sv =====
`default_nettype none

package v2dc_pkg;

    localparam int DIM_W     = 4;
    localparam int POS_W     = 3;
    localparam int VAL_W     = 32;
    localparam int OP_W      = 2;
    localparam int STEP_W    = 5;
    localparam int CFG_IDX_W = 2;

    localparam logic [OP_W-1:0] OP_LOAD_A  = 2'd0;
    localparam logic [OP_W-1:0] OP_LOAD_K  = 2'd1;
    localparam logic [OP_W-1:0] OP_COMPUTE = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_A_ROWS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_A_COLS = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_K_ROWS = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_K_COLS = 2'd3;

    typedef struct packed {
        logic a_shift;
        logic prod_en;
        logic acc_en;
        logic acc_clr;
        logic drain;
    } t_cell_ctrl;

    function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v,
                                                   input logic [DIM_W-1:0] maxv);
        logic [DIM_W-1:0] res;
        res = v;
        if (v == '0) begin
            res = DIM_W'(1);
        end else if (v > maxv) begin
            res = maxv;
        end
        return res;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/valid_2d_convolution.sv =====
// channel   valid         ready         payload
// input     i_in_valid    o_in_ready    i_opcode i_elem_row i_elem_col i_elem_value
// output    o_out_valid   i_out_ready   o_out_value o_out_row o_out_col o_last o_size_error
// config    i_cfg_we      -             i_cfg_index i_cfg_data
//
// Loads in range are written to the stores as they are accepted. For each output
// row, a compute request streams one input row per kernel row through a chain of
// MAX_COLS MAC cells, passes S_FLUSH1 and S_FLUSH2, then drains the accumulators
// from the head of the chain, one result per cycle while the output is not stalled.
// Synchronous active-low reset; the stores are not cleared.
// Output stalls hold the drain; a new request is taken while a result waits.
`default_nettype none

`include "valid_2d_convolution_defines.svh"

module valid_2d_convolution
    import v2dc_pkg::*;
#(
    parameter int MAX_ROWS = 8,
    parameter int MAX_COLS = 8
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [DIM_W-1:0]     i_cfg_data,
    input  wire logic                 i_in_valid,
    output logic                      o_in_ready,
    input  wire logic [OP_W-1:0]      i_opcode,
    input  wire logic [POS_W-1:0]     i_elem_row,
    input  wire logic [POS_W-1:0]     i_elem_col,
    input  wire logic signed [VAL_W-1:0] i_elem_value,
    output logic                      o_out_valid,
    input  wire logic                 i_out_ready,
    output logic signed [VAL_W-1:0]   o_out_value,
    output logic      [POS_W-1:0]     o_out_row,
    output logic      [POS_W-1:0]     o_out_col,
    output logic                      o_last,
    output logic                      o_size_error
);

    localparam int DEPTH  = MAX_ROWS * MAX_COLS;
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int FULL_W = 2 * DIM_W + 2;
    localparam logic [DIM_W-1:0]  MAXR_D = DIM_W'(MAX_ROWS);
    localparam logic [DIM_W-1:0]  MAXC_D = DIM_W'(MAX_COLS);
    localparam logic [STEP_W-1:0] STEP_N = STEP_W'(MAX_COLS);

    typedef enum logic [2:0] {
        S_IDLE,
        S_RUN,
        S_FLUSH1,
        S_FLUSH2,
        S_EMIT,
        S_ERR
    } t_state;

    function automatic logic [ADDR_W-1:0] addr_of(input logic [DIM_W-1:0] row,
                                                  input logic [DIM_W-1:0] col);
        logic [FULL_W-1:0] full;
        full = FULL_W'(row) * FULL_W'(MAX_COLS) + FULL_W'(col);
        return full[ADDR_W-1:0];
    endfunction

    t_state r_state, n_state;
    logic [DIM_W-1:0]  r_a_rows, r_a_cols, r_k_rows, r_k_cols;
    logic [DIM_W-1:0]  r_i, n_i, r_r, n_r, r_j, n_j;
    logic [STEP_W-1:0] r_t, n_t;
    logic              r_s1_shift, r_s1_mac, r_s1_clr, r_s2_mac, r_s2_clr;
    logic              r_out_valid, n_out_valid;
    logic [VAL_W-1:0]  r_out_value, n_out_value;
    logic [POS_W-1:0]  r_out_row, n_out_row, r_out_col, n_out_col;
    logic              r_out_last, n_out_last, r_out_err, n_out_err;

    logic [DIM_W-1:0]  ar, ac, kr, kc, orows, ocols;
    logic [DIM_W-1:0]  a_row, a_col, k_row, k_col;
    logic [STEP_W-1:0] last_t, k_off;
    logic              size_err, out_free, issue, issue_mac, issue_clr, emit_load;
    logic              in_acc, load_ok;
    logic [ADDR_W-1:0] waddr, a_raddr, k_raddr;
    logic [VAL_W-1:0]  a_rdata, k_rdata, acc_head;
    t_cell_ctrl        cell_ctrl;

    assign ar       = clamp_dim(r_a_rows, MAXR_D);
    assign ac       = clamp_dim(r_a_cols, MAXC_D);
    assign kr       = clamp_dim(r_k_rows, MAXR_D);
    assign kc       = clamp_dim(r_k_cols, MAXC_D);
    assign size_err = (kr > ar) || (kc > ac);
    assign orows    = ar - kr + DIM_W'(1);
    assign ocols    = ac - kc + DIM_W'(1);
    assign last_t   = STEP_N + STEP_W'(kc) - STEP_W'(1);
    assign out_free = !r_out_valid || i_out_ready;

    assign o_in_ready = (r_state == S_IDLE);
    assign in_acc     = i_in_valid && o_in_ready;
    assign load_ok    = (DIM_W'(i_elem_row) < MAXR_D) && (DIM_W'(i_elem_col) < MAXC_D);
    assign waddr      = addr_of(DIM_W'(i_elem_row), DIM_W'(i_elem_col));

    // read addresses for the current stream step
    always_comb begin
        k_off   = r_t - STEP_N;
        a_row   = r_i + r_r;
        a_col   = (r_t < STEP_N) ? r_t[DIM_W-1:0] : '0;
        k_row   = kr - DIM_W'(1) - r_r;
        k_col   = (r_t >= STEP_N) ? (kc - DIM_W'(1) - k_off[DIM_W-1:0]) : '0;
        a_raddr = addr_of(a_row, a_col);
        k_raddr = addr_of(k_row, k_col);
    end

    v2dc_ram #(
        .WIDTH (VAL_W),
        .DEPTH (DEPTH)
    ) u_input_store (
        .i_clk   (i_clk),
        .i_we    (in_acc && (i_opcode == OP_LOAD_A) && load_ok),
        .i_waddr (waddr),
        .i_wdata (i_elem_value),
        .i_raddr (a_raddr),
        .o_rdata (a_rdata)
    );

    v2dc_ram #(
        .WIDTH (VAL_W),
        .DEPTH (DEPTH)
    ) u_kernel_store (
        .i_clk   (i_clk),
        .i_we    (in_acc && (i_opcode == OP_LOAD_K) && load_ok),
        .i_waddr (waddr),
        .i_wdata (i_elem_value),
        .i_raddr (k_raddr),
        .o_rdata (k_rdata)
    );

    always_comb begin
        cell_ctrl.a_shift = r_s1_shift;
        cell_ctrl.prod_en = r_s1_mac;
        cell_ctrl.acc_en  = r_s2_mac;
        cell_ctrl.acc_clr = r_s2_clr;
        cell_ctrl.drain   = emit_load;
    end

    v2dc_chain #(
        .N_CELLS (MAX_COLS)
    ) u_chain (
        .i_clk      (i_clk),
        .i_ctrl     (cell_ctrl),
        .i_a_tail   (a_rdata),
        .i_weight   (k_rdata),
        .o_acc_head (acc_head)
    );

    always_comb begin
        n_state     = r_state;
        n_i         = r_i;
        n_r         = r_r;
        n_t         = r_t;
        n_j         = r_j;
        n_out_valid = r_out_valid && !i_out_ready;
        n_out_value = r_out_value;
        n_out_row   = r_out_row;
        n_out_col   = r_out_col;
        n_out_last  = r_out_last;
        n_out_err   = r_out_err;
        issue       = 1'b0;
        issue_mac   = 1'b0;
        issue_clr   = 1'b0;
        emit_load   = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (in_acc && (i_opcode == OP_COMPUTE)) begin
                    if (size_err) begin
                        n_state = S_ERR;
                    end else begin
                        n_state = S_RUN;
                        n_i     = '0;
                        n_r     = '0;
                        n_t     = '0;
                    end
                end
            end
            S_RUN: begin
                issue     = 1'b1;
                issue_mac = (r_t >= STEP_N);
                issue_clr = (r_r == '0) && (r_t == STEP_N);
                if (r_t == last_t) begin
                    n_t = '0;
                    if (r_r == kr - DIM_W'(1)) begin
                        n_state = S_FLUSH1;
                    end else begin
                        n_r = r_r + DIM_W'(1);
                    end
                end else begin
                    n_t = r_t + STEP_W'(1);
                end
            end
            S_FLUSH1: begin
                n_state = S_FLUSH2;
            end
            S_FLUSH2: begin
                n_state = S_EMIT;
                n_j     = '0;
            end
            S_EMIT: begin
                if (out_free) begin
                    emit_load   = 1'b1;
                    n_out_valid = 1'b1;
                    n_out_value = acc_head;
                    n_out_row   = r_i[POS_W-1:0];
                    n_out_col   = r_j[POS_W-1:0];
                    n_out_last  = (r_i == orows - DIM_W'(1)) && (r_j == ocols - DIM_W'(1));
                    n_out_err   = 1'b0;
                    if (r_j == ocols - DIM_W'(1)) begin
                        n_j = '0;
                        if (r_i == orows - DIM_W'(1)) begin
                            n_state = S_IDLE;
                        end else begin
                            n_i     = r_i + DIM_W'(1);
                            n_r     = '0;
                            n_t     = '0;
                            n_state = S_RUN;
                        end
                    end else begin
                        n_j = r_j + DIM_W'(1);
                    end
                end
            end
            S_ERR: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out_value = '0;
                    n_out_row   = '0;
                    n_out_col   = '0;
                    n_out_last  = 1'b1;
                    n_out_err   = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_a_rows    <= DIM_W'(8);
            r_a_cols    <= DIM_W'(8);
            r_k_rows    <= DIM_W'(1);
            r_k_cols    <= DIM_W'(1);
            r_i         <= '0;
            r_r         <= '0;
            r_t         <= '0;
            r_j         <= '0;
            r_s1_shift  <= 1'b0;
            r_s1_mac    <= 1'b0;
            r_s1_clr    <= 1'b0;
            r_s2_mac    <= 1'b0;
            r_s2_clr    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_i         <= n_i;
            r_r         <= n_r;
            r_t         <= n_t;
            r_j         <= n_j;
            r_s1_shift  <= issue;
            r_s1_mac    <= issue_mac;
            r_s1_clr    <= issue_clr;
            r_s2_mac    <= r_s1_mac;
            r_s2_clr    <= r_s1_clr;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_A_ROWS: r_a_rows <= i_cfg_data;
                    CFG_A_COLS: r_a_cols <= i_cfg_data;
                    CFG_K_ROWS: r_k_rows <= i_cfg_data;
                    CFG_K_COLS: r_k_cols <= i_cfg_data;
                    default: begin
                    end
                endcase
            end
        end
        r_out_value <= n_out_value;
        r_out_row   <= n_out_row;
        r_out_col   <= n_out_col;
        r_out_last  <= n_out_last;
        r_out_err   <= n_out_err;
    end

    assign o_out_valid  = r_out_valid;
    assign o_out_value  = r_out_value;
    assign o_out_row    = r_out_row;
    assign o_out_col    = r_out_col;
    assign o_last       = r_out_last;
    assign o_size_error = r_out_err;

    `V2DC_ASSERT_IMP(a_busy_no_req, i_clk, i_rst_n, r_state != S_IDLE, !o_in_ready)
    `V2DC_ASSERT_NXT(a_last_to_idle, i_clk, i_rst_n, emit_load && n_out_last, r_state == S_IDLE)
    `V2DC_ASSERT_IMP(a_err_is_last, i_clk, i_rst_n, o_out_valid && o_size_error, o_last)
    `V2DC_ASSERT_IMP(a_no_mac_drain, i_clk, i_rst_n, r_state == S_EMIT, !r_s2_mac && !r_s1_mac)

endmodule

`default_nettype wire

// ===== rtl/v2dc_ram.sv =====
`default_nettype none

module v2dc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic              i_clk,
    input  wire logic              i_we,
    input  wire logic [ADDR_W-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]  i_wdata,
    input  wire logic [ADDR_W-1:0] i_raddr,
    output logic      [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// ===== rtl/v2dc_cell.sv =====
`default_nettype none

module v2dc_cell
    import v2dc_pkg::*;
(
    input  wire logic             i_clk,
    input  wire t_cell_ctrl       i_ctrl,
    input  wire logic [VAL_W-1:0] i_a_next,
    input  wire logic [VAL_W-1:0] i_acc_next,
    input  wire logic [VAL_W-1:0] i_weight,
    output logic      [VAL_W-1:0] o_a,
    output logic      [VAL_W-1:0] o_acc
);

    logic [VAL_W-1:0] r_a;
    logic [VAL_W-1:0] r_p;
    logic [VAL_W-1:0] r_acc;

    // low word of the product is all that survives the wrapping sum
    always_ff @(posedge i_clk) begin
        if (i_ctrl.a_shift) begin
            r_a <= i_a_next;
        end
        if (i_ctrl.prod_en) begin
            r_p <= r_a * i_weight;
        end
        if (i_ctrl.drain) begin
            r_acc <= i_acc_next;
        end else if (i_ctrl.acc_en) begin
            r_acc <= i_ctrl.acc_clr ? r_p : r_acc + r_p;
        end
    end

    assign o_a   = r_a;
    assign o_acc = r_acc;

endmodule

`default_nettype wire

// ===== rtl/v2dc_chain.sv =====
`default_nettype none

module v2dc_chain
    import v2dc_pkg::*;
#(
    parameter int N_CELLS = 8
) (
    input  wire logic             i_clk,
    input  wire t_cell_ctrl       i_ctrl,
    input  wire logic [VAL_W-1:0] i_a_tail,
    input  wire logic [VAL_W-1:0] i_weight,
    output logic      [VAL_W-1:0] o_acc_head
);

    logic [VAL_W-1:0] a_link   [N_CELLS+1];
    logic [VAL_W-1:0] acc_link [N_CELLS+1];

    // samples enter at the tail and move one cell toward the head per shift
    assign a_link[N_CELLS]   = i_a_tail;
    assign acc_link[N_CELLS] = '0;

    for (genvar g = 0; g < N_CELLS; g++) begin : g_cell
        v2dc_cell u_cell (
            .i_clk      (i_clk),
            .i_ctrl     (i_ctrl),
            .i_a_next   (a_link[g+1]),
            .i_acc_next (acc_link[g+1]),
            .i_weight   (i_weight),
            .o_a        (a_link[g]),
            .o_acc      (acc_link[g])
        );
    end

    assign o_acc_head = acc_link[0];

endmodule

`default_nettype wire
